FILE: src/cmeg_pkg.sv
package cmeg_pkg;

	localparam int MAX_SEGMENTS = 256;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	localparam int SEG_W = 9;
	localparam int IDX_W = 17;
	localparam int ANG_W = 32;
	localparam int CW = 34;
	localparam int PW = 51;
	localparam int QW = 25;
	localparam int PRW = 10;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;

	localparam int N_IDIV = IDX_W;
	localparam int AT_MUL = N_IDIV;
	localparam int AT_ADIV = AT_MUL + 1;
	localparam int N_ADIV = ANG_W;
	localparam int N_PDIV = QW;
	localparam int AT_COR = AT_ADIV + N_ADIV;
	localparam int AT_PROD = AT_COR + CORDIC_ITERS;
	localparam int N_PIPE = AT_PROD + 1;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [PW-1:0] POS_MAX = 51'sd65535;
	localparam logic signed [PW-1:0] POS_MIN = -51'sd65535;
	localparam logic signed [CW-1:0] NRM_MAX = 34'sd16384;
	localparam logic signed [CW-1:0] NRM_MIN = -34'sd16384;

	typedef enum logic [1:0] {
		REG_RADIUS,
		REG_HEIGHT,
		REG_SEG_AROUND,
		REG_SEG_ALONG
	} reg_idx_t;

	typedef logic [SEG_W-1:0] seg_t;

	typedef struct packed {
		logic kind;
		logic oor;
		logic [IDX_W-1:0] index;
	} req_item_t;

	typedef struct packed {
		logic kind;
		logic oor;
		logic odd;
		logic flip;
		logic [SEG_W-1:0] rem;
		logic [IDX_W-1:0] dq;
		logic [PRW-1:0] prem;
		logic [QW-1:0] pdq;
		logic [SEG_W-1:0] arem;
		logic [ANG_W-1:0] aq;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
		logic [IDX_W-1:0] ca;
		logic [IDX_W-1:0] cb;
		logic [IDX_W-1:0] cc;
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] pz;
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] nz;
	} pipe_t;

	function automatic seg_t clamp_seg(input seg_t v, input seg_t lo);
		seg_t r;
		if (v < lo) begin
			r = lo;
		end else if (v > SEG_W'(MAX_SEGMENTS)) begin
			r = SEG_W'(MAX_SEGMENTS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [31:0] atan_turn(input int k);
		logic [31:0] r;
		case (k)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/cmeg_if.sv
interface cmeg_req_if;
	logic valid;
	logic ready;
	logic func;
	logic [16:0] element_index;
	modport source(output valid, func, element_index, input ready);
	modport sink(input valid, func, element_index, output ready);
endinterface

interface cmeg_rsp_if;
	logic valid;
	logic ready;
	logic kind;
	logic out_of_range;
	logic signed [16:0] pos_x;
	logic [15:0] pos_y;
	logic signed [16:0] pos_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_z;
	logic [16:0] corner_a;
	logic [16:0] corner_b;
	logic [16:0] corner_c;
	modport source(output valid, kind, out_of_range, pos_x, pos_y, pos_z, normal_x, normal_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink(input valid, kind, out_of_range, pos_x, pos_y, pos_z, normal_x, normal_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

FILE: src/cylinder_mesh_element_generator.sv
// open cylinder mesh element generator
// req channel: func (0 vertex, 1 triangle) and element_index, valid/ready
// rsp channel: one item per request, in request order, valid/ready
//   vertex: position q8.8 and unit normal q1.14 from a pipelined cordic
//   triangle: three vertex indices of one half of a quad
//   an index past the vertex or triangle count sets out_of_range, data fields 0
// throughput: one item per cycle when rsp.ready stays high
// from the req accept to rsp valid an item passes through 70 registers
//   (1 front stage, 1 queue, 17 index divide steps, 1 multiply,
//   32 angle divide steps, 16 cordic steps, 1 product stage, 1 output register)
// a 4-entry queue separates the front stage from the back pipeline
// when rsp.valid is high and rsp.ready is low the whole back pipeline holds, the queue fills,
//   then req.ready drops
// apb port: radius at 0x0, height at 0x4, segments around at 0x8,
//   segments along at 0xc; write only while no item is in flight
// reset: empties queue and pipeline, registers go to radius 1.0,
//   height 1.0, 16 segments around, 1 segment along
module cylinder_mesh_element_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	cmeg_req_if.sink    req,
	cmeg_rsp_if.source  rsp
);

	logic [15:0] radius_q;
	logic [15:0] height_q;
	cmeg_pkg::seg_t seg_around_q;
	cmeg_pkg::seg_t seg_along_q;
	cmeg_pkg::seg_t seg_u;
	cmeg_pkg::seg_t seg_v;
	cmeg_pkg::reg_idx_t reg_sel;
	logic push_valid;
	logic push_ready;
	cmeg_pkg::req_item_t push_item;
	logic pop_valid;
	logic pop_ready;
	cmeg_pkg::req_item_t pop_item;

	assign pready = 1'b1;
	assign reg_sel = cmeg_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			height_q <= 16'd256;
			seg_around_q <= 9'd16;
			seg_along_q <= 9'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				cmeg_pkg::REG_RADIUS: radius_q <= pwdata[15:0];
				cmeg_pkg::REG_HEIGHT: height_q <= pwdata[15:0];
				cmeg_pkg::REG_SEG_AROUND: seg_around_q <= pwdata[8:0];
				cmeg_pkg::REG_SEG_ALONG: seg_along_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			cmeg_pkg::REG_RADIUS: prdata = 32'(radius_q);
			cmeg_pkg::REG_HEIGHT: prdata = 32'(height_q);
			cmeg_pkg::REG_SEG_AROUND: prdata = 32'(seg_around_q);
			cmeg_pkg::REG_SEG_ALONG: prdata = 32'(seg_along_q);
			default: prdata = '0;
		endcase
	end

	assign seg_u = cmeg_pkg::clamp_seg(seg_around_q, 9'd3);
	assign seg_v = cmeg_pkg::clamp_seg(seg_along_q, 9'd1);

	cmeg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.seg_u      (seg_u),
		.seg_v      (seg_v),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	cmeg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	cmeg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.seg_u     (seg_u),
		.seg_v     (seg_v),
		.radius    (radius_q),
		.height    (height_q),
		.rsp       (rsp)
	);

endmodule

FILE: src/cmeg_front.sv
module cmeg_front (
	input  logic                clk,
	input  logic                arst_n,
	cmeg_req_if.sink            req,
	input  cmeg_pkg::seg_t      seg_u,
	input  cmeg_pkg::seg_t      seg_v,
	output logic                push_valid,
	input  logic                push_ready,
	output cmeg_pkg::req_item_t push_item
);

	logic [17:0] vtx_count;
	logic [17:0] tri_count;
	logic oor;
	logic vld_s1;
	cmeg_pkg::req_item_t item_s1;

	assign vtx_count = 18'(seg_u) * (18'(seg_v) + 18'd1);
	assign tri_count = (18'(seg_u) * 18'(seg_v)) << 1;
	assign oor = req.func ? (18'(req.element_index) >= tri_count)
		: (18'(req.element_index) >= vtx_count);

	assign req.ready = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.kind <= req.func;
			item_s1.oor <= oor;
			item_s1.index <= req.element_index;
		end
	end

endmodule

FILE: src/cmeg_queue.sv
module cmeg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  cmeg_pkg::req_item_t push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output cmeg_pkg::req_item_t pop_item
);

	cmeg_pkg::req_item_t mem_q [cmeg_pkg::Q_DEPTH];
	logic [cmeg_pkg::Q_AW-1:0] wr_q;
	logic [cmeg_pkg::Q_AW-1:0] rd_q;
	logic [cmeg_pkg::Q_AW:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = cnt_q != (cmeg_pkg::Q_AW + 1)'(cmeg_pkg::Q_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_item = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

FILE: src/cmeg_back.sv
module cmeg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  cmeg_pkg::req_item_t pop_item,
	input  cmeg_pkg::seg_t      seg_u,
	input  cmeg_pkg::seg_t      seg_v,
	input  logic [15:0]         radius,
	input  logic [15:0]         height,
	cmeg_rsp_if.source          rsp
);

	logic en;
	logic vld_s [cmeg_pkg::N_PIPE];
	cmeg_pkg::pipe_t pipe_s [cmeg_pkg::N_PIPE];
	cmeg_pkg::pipe_t head;
	cmeg_pkg::pipe_t last;
	logic [cmeg_pkg::PRW-1:0] v2;
	logic out_vld_q;
	logic signed [cmeg_pkg::PW-1:0] px_sh;
	logic signed [cmeg_pkg::PW-1:0] pz_sh;
	logic signed [cmeg_pkg::CW-1:0] nx_sh;
	logic signed [cmeg_pkg::CW-1:0] nz_sh;
	logic signed [16:0] px_f;
	logic signed [16:0] pz_f;
	logic signed [15:0] nx_f;
	logic signed [15:0] nz_f;
	logic vtx_ok;
	logic tri_ok;

	function automatic cmeg_pkg::pipe_t idiv_step(input cmeg_pkg::pipe_t p, input cmeg_pkg::seg_t u);
		logic [cmeg_pkg::SEG_W:0] t;
		logic qb;
		t = {p.rem, p.dq[cmeg_pkg::IDX_W-1]};
		qb = t >= {1'b0, u};
		if (qb) begin
			t = t - {1'b0, u};
		end
		p.rem = t[cmeg_pkg::SEG_W-1:0];
		p.dq = {p.dq[cmeg_pkg::IDX_W-2:0], qb};
		return p;
	endfunction

	function automatic cmeg_pkg::pipe_t mul_step(input cmeg_pkg::pipe_t p, input cmeg_pkg::seg_t u,
			input cmeg_pkg::seg_t v, input logic [15:0] h);
		cmeg_pkg::seg_t col;
		cmeg_pkg::seg_t ring;
		cmeg_pkg::seg_t nxt;
		logic [17:0] ru;
		logic [17:0] r1u;
		logic [24:0] hp;
		col = p.rem;
		ring = p.dq[cmeg_pkg::SEG_W-1:0];
		nxt = (10'(col) + 10'd1 == 10'(u)) ? '0 : cmeg_pkg::SEG_W'(10'(col) + 10'd1);
		ru = 18'(ring) * 18'(u);
		r1u = ru + 18'(u);
		if (!p.odd) begin
			p.ca = cmeg_pkg::IDX_W'(18'(col) + r1u);
			p.cb = cmeg_pkg::IDX_W'(18'(nxt) + r1u);
		end else begin
			p.ca = cmeg_pkg::IDX_W'(18'(nxt) + r1u);
			p.cb = cmeg_pkg::IDX_W'(18'(nxt) + ru);
		end
		p.cc = cmeg_pkg::IDX_W'(18'(col) + ru);
		hp = 25'(h) * 25'(ring);
		p.pdq = cmeg_pkg::QW'({hp, 1'b0} + 26'(v));
		p.prem = '0;
		p.arem = col;
		p.aq = '0;
		return p;
	endfunction

	function automatic cmeg_pkg::pipe_t adiv_step(input cmeg_pkg::pipe_t p, input cmeg_pkg::seg_t u);
		logic [cmeg_pkg::SEG_W:0] t;
		logic qb;
		t = {p.arem, 1'b0};
		qb = t >= {1'b0, u};
		if (qb) begin
			t = t - {1'b0, u};
		end
		p.arem = t[cmeg_pkg::SEG_W-1:0];
		p.aq = {p.aq[cmeg_pkg::ANG_W-2:0], qb};
		return p;
	endfunction

	function automatic cmeg_pkg::pipe_t pdiv_step(input cmeg_pkg::pipe_t p,
			input logic [cmeg_pkg::PRW-1:0] d);
		logic [cmeg_pkg::PRW:0] t;
		logic qb;
		t = {p.prem, p.pdq[cmeg_pkg::QW-1]};
		qb = t >= {1'b0, d};
		if (qb) begin
			t = t - {1'b0, d};
		end
		p.prem = t[cmeg_pkg::PRW-1:0];
		p.pdq = {p.pdq[cmeg_pkg::QW-2:0], qb};
		return p;
	endfunction

	function automatic cmeg_pkg::pipe_t cordic_init(input cmeg_pkg::pipe_t p);
		logic [31:0] ph;
		p.flip = p.aq[31] ^ p.aq[30];
		ph = p.flip ? (p.aq ^ 32'h8000_0000) : p.aq;
		p.cz = {{2{ph[31]}}, ph};
		p.cx = cmeg_pkg::CORDIC_GAIN;
		p.cy = '0;
		return p;
	endfunction

	function automatic cmeg_pkg::pipe_t cordic_step(input cmeg_pkg::pipe_t p, input int k);
		logic signed [cmeg_pkg::CW-1:0] dx;
		logic signed [cmeg_pkg::CW-1:0] dy;
		logic signed [cmeg_pkg::CW-1:0] at;
		dx = p.cy >>> k;
		dy = p.cx >>> k;
		at = {2'b00, cmeg_pkg::atan_turn(k)};
		if (!p.cz[cmeg_pkg::CW-1]) begin
			p.cx = p.cx - dx;
			p.cy = p.cy + dy;
			p.cz = p.cz - at;
		end else begin
			p.cx = p.cx + dx;
			p.cy = p.cy - dy;
			p.cz = p.cz + at;
		end
		return p;
	endfunction

	function automatic cmeg_pkg::pipe_t prod_step(input cmeg_pkg::pipe_t p, input logic [15:0] r);
		logic signed [cmeg_pkg::PW-1:0] rs;
		logic signed [cmeg_pkg::PW-1:0] half;
		rs = $signed(cmeg_pkg::PW'(r));
		half = $signed(cmeg_pkg::PW'(1)) <<< 29;
		p.px = rs * cmeg_pkg::PW'(p.cy) + half;
		p.pz = rs * cmeg_pkg::PW'(p.cx) + half;
		p.nx = p.cy + 34'sd32768;
		p.nz = p.cx + 34'sd32768;
		return p;
	endfunction

	assign en = !out_vld_q || rsp.ready;
	assign pop_ready = en;
	assign v2 = {seg_v, 1'b0};

	always_comb begin
		head = '0;
		head.kind = pop_item.kind;
		head.oor = pop_item.oor;
		head.odd = pop_item.index[0];
		head.dq = pop_item.kind ? {1'b0, pop_item.index[cmeg_pkg::IDX_W-1:1]} : pop_item.index;
	end

	for (genvar g = 0; g < cmeg_pkg::N_PIPE; g++) begin : g_stage
		cmeg_pkg::pipe_t src;
		cmeg_pkg::pipe_t d;
		logic vin;

		if (g == 0) begin : g_head
			assign src = head;
			assign vin = pop_valid;
		end else begin : g_body
			assign src = pipe_s[g-1];
			assign vin = vld_s[g-1];
		end

		always_comb begin
			d = src;
			if (g < cmeg_pkg::AT_MUL) begin
				d = idiv_step(d, seg_u);
			end else if (g == cmeg_pkg::AT_MUL) begin
				d = mul_step(d, seg_u, seg_v, height);
			end else if (g < cmeg_pkg::AT_COR) begin
				d = adiv_step(d, seg_u);
				if (g < cmeg_pkg::AT_ADIV + cmeg_pkg::N_PDIV) begin
					d = pdiv_step(d, v2);
				end
			end else if (g < cmeg_pkg::AT_PROD) begin
				if (g == cmeg_pkg::AT_COR) begin
					d = cordic_init(d);
				end
				d = cordic_step(d, g - cmeg_pkg::AT_COR);
				if (g == cmeg_pkg::AT_PROD - 1 && d.flip) begin
					d.cx = -d.cx;
					d.cy = -d.cy;
				end
			end else begin
				d = prod_step(d, radius);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[g] <= d;
			end
		end
	end

	assign last = pipe_s[cmeg_pkg::N_PIPE-1];
	assign px_sh = last.px >>> 30;
	assign pz_sh = last.pz >>> 30;
	assign nx_sh = last.nx >>> 16;
	assign nz_sh = last.nz >>> 16;

	always_comb begin
		if (px_sh > cmeg_pkg::POS_MAX) begin
			px_f = 17'sd65535;
		end else if (px_sh < cmeg_pkg::POS_MIN) begin
			px_f = -17'sd65535;
		end else begin
			px_f = px_sh[16:0];
		end
		if (pz_sh > cmeg_pkg::POS_MAX) begin
			pz_f = 17'sd65535;
		end else if (pz_sh < cmeg_pkg::POS_MIN) begin
			pz_f = -17'sd65535;
		end else begin
			pz_f = pz_sh[16:0];
		end
		if (nx_sh > cmeg_pkg::NRM_MAX) begin
			nx_f = 16'sd16384;
		end else if (nx_sh < cmeg_pkg::NRM_MIN) begin
			nx_f = -16'sd16384;
		end else begin
			nx_f = nx_sh[15:0];
		end
		if (nz_sh > cmeg_pkg::NRM_MAX) begin
			nz_f = 16'sd16384;
		end else if (nz_sh < cmeg_pkg::NRM_MIN) begin
			nz_f = -16'sd16384;
		end else begin
			nz_f = nz_sh[15:0];
		end
	end

	assign vtx_ok = !last.kind && !last.oor;
	assign tri_ok = last.kind && !last.oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[cmeg_pkg::N_PIPE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.kind <= last.kind;
			rsp.out_of_range <= last.oor;
			rsp.pos_x <= vtx_ok ? px_f : '0;
			rsp.pos_y <= vtx_ok ? last.pdq[15:0] : '0;
			rsp.pos_z <= vtx_ok ? pz_f : '0;
			rsp.normal_x <= vtx_ok ? nx_f : '0;
			rsp.normal_z <= vtx_ok ? nz_f : '0;
			rsp.corner_a <= tri_ok ? last.ca : '0;
			rsp.corner_b <= tri_ok ? last.cb : '0;
			rsp.corner_c <= tri_ok ? last.cc : '0;
		end
	end

	assign rsp.valid = out_vld_q;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_of_range |-> rsp.pos_y == '0 && rsp.corner_a == '0
			&& rsp.normal_x == '0 && rsp.pos_z == '0)
		else $error("out of range item carries data");

	a_tri_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind |-> rsp.pos_x == '0 && rsp.normal_z == '0)
		else $error("triangle item carries position");

	a_vtx_no_corner: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.kind |-> rsp.corner_a == '0 && rsp.corner_c == '0)
		else $error("vertex item carries corners");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !rsp.ready |=> out_vld_q && $stable(rsp.corner_b))
		else $error("output dropped under stall");

endmodule
